// ===== hdl/kpc_pkg.sv =====
// Shared types and constants for the KMP pattern counter.
`default_nettype none
package kpc_pkg;

    localparam int MAX_PATTERN_DEF = 64;
    localparam int COUNT_BITS_DEF  = 32;

    localparam int OP_W      = 2;
    localparam int SYM_W     = 8;
    localparam int OUT_CNT_W = 32;
    localparam int OUT_LEN_W = 7;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_TEXT   = 2'd2;

    typedef enum logic [1:0] {
        KIND_CLEAR,
        KIND_APPEND,
        KIND_TEXT,
        KIND_NOP
    } item_kind_t;

    typedef struct packed {
        item_kind_t       kind;
        logic [SYM_W-1:0] symbol;
    } queue_item_t;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } back_state_t;

endpackage
`default_nettype wire

// ===== hdl/kpc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module kpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hdl/kpc_front.sv =====
// Front end: accepts input items, classifies the op and queues them for the back end.
`default_nettype none
module kpc_front import kpc_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [OP_W-1:0]  s_op,
    input  wire logic [SYM_W-1:0] s_symbol,
    output logic                  q_valid,
    input  wire logic             q_ready,
    output queue_item_t           q_item
);

    queue_item_t entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    queue_item_t in_item;
    logic        push, pop;

    always_comb begin
        case (s_op)
            OP_CLEAR:  in_item.kind = KIND_CLEAR;
            OP_APPEND: in_item.kind = KIND_APPEND;
            OP_TEXT:   in_item.kind = KIND_TEXT;
            default:   in_item.kind = KIND_NOP;
        endcase
        in_item.symbol = s_symbol;
    end

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = entry_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/kpc_back.sv =====
// Back end: pattern and failure RAMs, the KMP fallback walk and the result register.
`default_nettype none
module kpc_back import kpc_pkg::*; #(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 q_valid,
    output logic                      q_ready,
    input  wire queue_item_t          q_item,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_match_found,
    output logic [OUT_CNT_W-1:0]      m_occurrence_count,
    output logic [OUT_LEN_W-1:0]      m_pattern_length,
    output logic                      m_pattern_full
);

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    back_state_t           state_reg, state_next;
    item_kind_t            kind_reg, kind_next;
    logic [SYM_W-1:0]      sym_reg, sym_next;
    logic [IDX_W-1:0]      k_reg, k_next;
    logic [LEN_W-1:0]      sl_reg, sl_next;
    logic [IDX_W-1:0]      bp_reg, bp_next;
    logic [IDX_W-1:0]      ml_reg, ml_next;
    logic [COUNT_BITS-1:0] total_reg, total_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  out_match_reg, out_match_next;
    logic [OUT_CNT_W-1:0]  out_count_reg, out_count_next;
    logic [OUT_LEN_W-1:0]  out_len_reg, out_len_next;
    logic                  out_full_reg, out_full_next;

    logic                  p_we, f_we;
    logic [IDX_W-1:0]      wr_addr;
    logic [IDX_W-1:0]      f_wdata;
    logic [SYM_W-1:0]      p_rdata;
    logic [IDX_W-1:0]      f_rdata;
    logic [IDX_W-1:0]      f_raddr;

    logic                  slot_free;
    logic                  sl_zero, sl_full;
    logic                  start_walk;
    logic                  fit, walk_done;
    logic [LEN_W-1:0]      k_res;
    logic                  produce, match_flag, full_flag;
    logic [63:0]           total_wide;
    logic [LEN_W+6:0]      len_wide;

    kpc_ram #(.WIDTH(SYM_W), .DEPTH(MAX_PATTERN)) u_pattern_ram (
        .aclk  (aclk),
        .we    (p_we),
        .waddr (wr_addr),
        .wdata (sym_next),
        .raddr (k_next),
        .rdata (p_rdata)
    );

    kpc_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PATTERN)) u_failure_ram (
        .aclk  (aclk),
        .we    (f_we),
        .waddr (wr_addr),
        .wdata (f_wdata),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    assign slot_free = !out_valid_reg || m_ready;
    assign sl_zero   = (sl_reg == '0);
    assign sl_full   = (sl_reg == LEN_W'(MAX_PATTERN));
    assign start_walk = ((q_item.kind == KIND_APPEND) && !sl_full && !sl_zero) ||
                        ((q_item.kind == KIND_TEXT) && !sl_zero);
    assign fit       = (p_rdata == sym_reg);
    assign walk_done = (k_reg == '0) || fit;
    assign k_res     = LEN_W'(k_reg) + LEN_W'(fit);
    assign f_raddr   = k_next - IDX_W'(1);
    assign wr_addr   = sl_reg[IDX_W-1:0];
    assign q_ready   = (state_reg == ST_IDLE) && slot_free;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid && slot_free && start_walk) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (walk_done && slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        kind_next  = kind_reg;
        sym_next   = sym_reg;
        k_next     = k_reg;
        sl_next    = sl_reg;
        bp_next    = bp_reg;
        ml_next    = ml_reg;
        total_next = total_reg;
        p_we       = 1'b0;
        f_we       = 1'b0;
        f_wdata    = '0;
        produce    = 1'b0;
        match_flag = 1'b0;
        full_flag  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid && slot_free) begin
                    kind_next = q_item.kind;
                    sym_next  = q_item.symbol;
                    case (q_item.kind)
                        KIND_CLEAR: begin
                            sl_next    = '0;
                            bp_next    = '0;
                            ml_next    = '0;
                            total_next = '0;
                            produce    = 1'b1;
                        end
                        KIND_APPEND: begin
                            if (sl_full) begin
                                full_flag = 1'b1;
                                produce   = 1'b1;
                            end else if (sl_zero) begin
                                // first byte: its border is empty
                                p_we    = 1'b1;
                                f_we    = 1'b1;
                                bp_next = '0;
                                sl_next = LEN_W'(1);
                                produce = 1'b1;
                            end else begin
                                k_next = (LEN_W'(bp_reg) < sl_reg) ? bp_reg : '0;
                            end
                        end
                        KIND_TEXT: begin
                            if (sl_zero) begin
                                produce = 1'b1;
                            end else begin
                                k_next = (LEN_W'(ml_reg) < sl_reg) ? ml_reg : '0;
                            end
                        end
                        default: produce = 1'b1;
                    endcase
                end
            end
            ST_WALK: begin
                if (!walk_done) begin
                    // fall back one border
                    k_next = (f_rdata < k_reg) ? f_rdata : '0;
                end else if (slot_free) begin
                    produce = 1'b1;
                    if (kind_reg == KIND_APPEND) begin
                        f_wdata = (k_res >= sl_reg) ? '0 : k_res[IDX_W-1:0];
                        p_we    = 1'b1;
                        f_we    = 1'b1;
                        bp_next = f_wdata;
                        sl_next = sl_reg + LEN_W'(1);
                    end else begin
                        if (k_res >= sl_reg) begin
                            // full occurrence: restart from the border of the whole pattern
                            match_flag = 1'b1;
                            if (total_reg != '1) begin
                                total_next = total_reg + COUNT_BITS'(1);
                            end
                            ml_next = (LEN_W'(bp_reg) < sl_reg) ? bp_reg : '0;
                        end else begin
                            ml_next = k_res[IDX_W-1:0];
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        total_wide     = 64'(total_next);
        len_wide       = (LEN_W+7)'(sl_next);
        out_valid_next = produce ? 1'b1 : (out_valid_reg && !m_ready);
        out_match_next = out_match_reg;
        out_count_next = out_count_reg;
        out_len_next   = out_len_reg;
        out_full_next  = out_full_reg;
        if (produce) begin
            out_match_next = match_flag;
            out_count_next = total_wide[OUT_CNT_W-1:0];
            out_len_next   = len_wide[OUT_LEN_W-1:0];
            out_full_next  = full_flag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sl_reg        <= '0;
            bp_reg        <= '0;
            ml_reg        <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sl_reg        <= sl_next;
            bp_reg        <= bp_next;
            ml_reg        <= ml_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg      <= kind_next;
        sym_reg       <= sym_next;
        k_reg         <= k_next;
        out_match_reg <= out_match_next;
        out_count_reg <= out_count_next;
        out_len_reg   <= out_len_next;
        out_full_reg  <= out_full_next;
    end

    assign m_valid            = out_valid_reg;
    assign m_match_found      = out_match_reg;
    assign m_occurrence_count = out_count_reg;
    assign m_pattern_length   = out_len_reg;
    assign m_pattern_full     = out_full_reg;

endmodule
`default_nettype wire

// ===== hdl/kmp_pattern_counter_unit.sv =====
// Clear, unused op, first or refused append and text on an empty pattern are queued in
// the front end and answered from the back end's idle state into the result register;
// other append and text bytes also walk, one RAM read per failure-table fallback step,
// until the symbol fits or the border is empty; no new item is taken during a walk.
// Reset clears lengths, match state, count, queue and result valid flag; pattern and
// failure RAMs hold undefined data until written and get no clearing pass.
`default_nettype none
module kmp_pattern_counter_unit import kpc_pkg::*; #(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [OP_W-1:0]      s_op,
    input  wire logic [SYM_W-1:0]     s_symbol,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_match_found,
    output logic [OUT_CNT_W-1:0]      m_occurrence_count,
    output logic [OUT_LEN_W-1:0]      m_pattern_length,
    output logic                      m_pattern_full
);

    logic        q_valid;
    logic        q_ready;
    queue_item_t q_item;

    kpc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_op     (s_op),
        .s_symbol (s_symbol),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    kpc_back #(
        .MAX_PATTERN (MAX_PATTERN),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .q_valid            (q_valid),
        .q_ready            (q_ready),
        .q_item             (q_item),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_match_found      (m_match_found),
        .m_occurrence_count (m_occurrence_count),
        .m_pattern_length   (m_pattern_length),
        .m_pattern_full     (m_pattern_full)
    );

endmodule
`default_nettype wire
